FILE: sv/srr_pkg.sv
package srr_pkg;

  localparam int unsigned SEQ_W = 32;
  localparam int unsigned SIZE_W = 16;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_DUP       = 4'd1,
    ST_BUFFERED  = 4'd2,
    ST_ZERO      = 4'd3,
    ST_OVERSIZE  = 4'd4,
    ST_WINDOW    = 4'd5,
    ST_BUSY      = 4'd6,
    ST_DONE      = 4'd7,
    ST_MISMATCH  = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    PC_IDLE    = 2'd0,
    PC_STREAM  = 2'd1,
    PC_STORE   = 2'd2,
    PC_DISCARD = 2'd3
  } pclass_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [SIZE_W-1:0] size;
    logic [7:0]        data;
    logic              tick;
    logic              last;
  } item_t;

  typedef struct packed {
    logic              ack_valid;
    logic [SEQ_W-1:0]  ack_seq;
    logic              out_valid;
    logic [7:0]        out_byte;
    logic              packet_end;
    logic              drain_pending;
    logic              finished;
    logic [3:0]        status;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_read;
  } dp_stat_t;

endpackage

FILE: sv/selective_repeat_reorder_receiver.sv
// selective repeat reorder receiver
// s_axis carries one packet byte or one drain tick per transfer; tuser bit 0
// is the opcode (1 = tick), tlast marks the last byte of a packet.
// m_axis returns exactly one result per accepted input transfer: ack, an
// in-order byte, drain pending, finished and a status code; tlast carries
// packet end.
// end_sequence is written through cfg_we/cfg_data; the user must do this only
// while the block is idle, as the block itself does not enforce it.
// a packet byte passes through capture and execute, a tick through capture,
// slot memory read and execute; the result then waits in the output register
// until taken. one item is in flight at a time: a new transfer is accepted
// only after the previous result has been taken.
// while m_axis_tready is low the result holds and s_axis_tready stays low.
// reset clears expected sequence, slot valid bits, packet state and flags;
// end_sequence returns to all ones. stored slot bytes and lengths are
// not cleared and are only read below a written length.
module selective_repeat_reorder_receiver import srr_pkg::*; #(
  parameter int unsigned WINDOW = 8,
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // seq_num, payload_size, data_byte
  input  logic        s_axis_tuser,  // opcode
  input  logic        s_axis_tlast,  // beat_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // ack_valid, ack_seq, out_valid, out_byte,
                                     // drain_pending, finished, status
  output logic        m_axis_tlast   // packet_end
);

  item_t    item_in;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  result_t  res;

  assign item_in.seq  = s_axis_tdata[31:0];
  assign item_in.size = s_axis_tdata[47:32];
  assign item_in.data = s_axis_tdata[55:48];
  assign item_in.tick = s_axis_tuser;
  assign item_in.last = s_axis_tlast;

  srr_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
    .stat(stat), .cmd(cmd)
  );

  srr_dp #(.WINDOW(WINDOW), .MAX_PAYLOAD(MAX_PAYLOAD)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .item_in(item_in), .cmd(cmd), .stat(stat), .res(res)
  );

  assign m_axis_tdata = {res.status, res.finished, res.drain_pending,
                         res.out_byte, res.out_valid,
                         res.ack_seq, res.ack_valid};
  assign m_axis_tlast = res.packet_end;

endmodule

FILE: sv/srr_ctrl.sv
module srr_ctrl import srr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     res_valid,
  input  logic     res_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_OUT);

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      // the drain byte is read from slot memory here
      S_READ: begin
        if (stat.need_read) begin
          state_next = S_EXEC;
        end else begin
          cmd.execute = 1'b1;
          state_next  = S_OUT;
        end
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

FILE: sv/srr_dp.sv
module srr_dp import srr_pkg::*; #(
  parameter int unsigned WINDOW = 8,
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [SEQ_W-1:0] cfg_data,
  input  item_t            item_in,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  output result_t          res
);

  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned PTR_W = $clog2(MAX_PAYLOAD);
  localparam int unsigned ADDR_W = $clog2(WINDOW * MAX_PAYLOAD);
  localparam int unsigned DEPTH = WINDOW * MAX_PAYLOAD;

  logic [SEQ_W-1:0]  end_seq;
  logic [SEQ_W-1:0]  expected_seq;
  logic [WINDOW-1:0] slot_valid;
  logic [LEN_W-1:0]  slot_length [WINDOW];
  logic [7:0]        slot_bytes [DEPTH];
  logic [SIZE_W-1:0] byte_position;
  pclass_t           packet_class;
  logic [LEN_W-1:0]  drain_pointer;
  logic              m_drain, m_final, m_done, m_end;
  status_t           drop_code;
  logic [SLOT_W-1:0] store_slot;
  item_t             it;
  logic [7:0]        rd_byte;
  logic [SLOT_W-1:0] exp_slot;

  // slot of the next expected sequence; the wrap to zero lands on slot zero
  function automatic logic [SLOT_W-1:0] slot_step(input logic [SLOT_W-1:0] s,
                                                  input logic [SEQ_W-1:0] nseq);
    if (nseq == '0) return '0;
    if (s == SLOT_W'(WINDOW - 1)) return '0;
    return s + 1'b1;
  endfunction

  // slot of a sequence ahead of expected by less than WINDOW
  function automatic logic [SLOT_W-1:0] slot_ahead(input logic [SLOT_W-1:0] base,
                                                   input logic [SEQ_W-1:0] d);
    logic [SLOT_W:0] sum;
    sum = {1'b0, base} + {1'b0, d[SLOT_W-1:0]};
    if (sum >= (SLOT_W+1)'(WINDOW)) sum = sum - (SLOT_W+1)'(WINDOW);
    return sum[SLOT_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [SLOT_W-1:0] s,
                                                input logic [PTR_W-1:0] p);
    logic [ADDR_W+SLOT_W-1:0] a;
    a = (ADDR_W+SLOT_W)'(s) * (ADDR_W+SLOT_W)'(MAX_PAYLOAD) + (ADDR_W+SLOT_W)'(p);
    return a[ADDR_W-1:0];
  endfunction

  assign stat.need_read = it.tick;

  // read of the drain byte in the cycle after capture
  always_ff @(posedge clk) begin
    rd_byte <= slot_bytes[addr_of(exp_slot, drain_pointer[PTR_W-1:0])];
  end

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  always_ff @(posedge clk) begin
    if (wr_en) slot_bytes[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) it <= item_in;
    if (rst) end_seq <= '1;
    else if (cfg_we) end_seq <= cfg_data;
  end

  logic [SEQ_W-1:0]  n_exp;
  logic [SLOT_W-1:0] n_es;
  logic [WINDOW-1:0] n_sv;
  logic [SIZE_W-1:0] n_pos;
  pclass_t           n_pc;
  logic [LEN_W-1:0]  n_dp;
  logic              n_drain, n_final, n_done, n_end;
  status_t           n_drop;
  logic [SLOT_W-1:0] n_ss;
  logic              len_we;
  logic [LEN_W-1:0]  len_wd;
  result_t           r;
  logic [LEN_W-1:0]  dlen;
  logic [SEQ_W-1:0]  diff;
  logic              fits, bad;
  logic [SIZE_W:0]   cnt;
  logic [SLOT_W-1:0] nslot;
  logic [SLOT_W-1:0] in_slot;

  always_comb begin
    n_exp = expected_seq; n_es = exp_slot; n_sv = slot_valid; n_pos = byte_position;
    n_pc = packet_class; n_dp = drain_pointer; n_drain = m_drain;
    n_final = m_final; n_done = m_done; n_end = m_end; n_drop = drop_code;
    n_ss = store_slot; len_we = 1'b0; len_wd = '0;
    wr_en = 1'b0; wr_addr = '0; wr_data = it.data;
    r = '0; dlen = slot_length[exp_slot]; diff = it.seq - expected_seq;
    fits = 1'b0; bad = 1'b0; cnt = '0; nslot = '0;
    in_slot = slot_ahead(exp_slot, diff);
    if (m_done) begin
      r.status = ST_DONE;
    end else if (it.tick) begin
      if (m_drain) begin
        if (!slot_valid[exp_slot] || dlen == '0 || drain_pointer >= dlen ||
            dlen > LEN_W'(MAX_PAYLOAD)) begin
          n_drain = 1'b0;
          if (m_final) n_done = 1'b1;
        end else begin
          if (drain_pointer == '0 && !m_final) begin
            r.ack_valid = 1'b1;
            r.ack_seq   = expected_seq;
          end
          r.out_valid = 1'b1;
          r.out_byte  = rd_byte;
          if (drain_pointer + 1'b1 >= dlen) begin
            r.packet_end = 1'b1;
            n_sv[exp_slot] = 1'b0;
            n_exp = expected_seq + 1'b1;
            n_dp = '0;
            nslot = slot_step(exp_slot, n_exp);
            n_es = nslot;
            if (n_sv[nslot]) n_drain = 1'b1;
            else begin
              n_drain = 1'b0;
              if (m_final) n_done = 1'b1;
            end
          end else begin
            n_dp = drain_pointer + 1'b1;
          end
        end
      end
    end else if (packet_class == PC_IDLE && it.size == '0) begin
      r.status = ST_ZERO;
    end else begin
      if (packet_class == PC_IDLE) begin
        n_pos = '0; n_pc = PC_DISCARD; n_drop = ST_OK;
        if (m_drain) n_drop = ST_BUSY;
        else if (it.seq == end_seq) n_end = 1'b1;
        else if (it.seq < expected_seq) begin
          n_drop = ST_DUP; r.ack_valid = 1'b1; r.ack_seq = it.seq;
        end else if (it.size > SIZE_W'(MAX_PAYLOAD)) n_drop = ST_OVERSIZE;
        else if (it.seq == expected_seq) n_pc = PC_STREAM;
        else if (diff >= SEQ_W'(WINDOW)) n_drop = ST_WINDOW;
        else begin
          r.ack_valid = 1'b1; r.ack_seq = it.seq;
          if (slot_valid[in_slot]) n_drop = ST_BUFFERED;
          else begin
            n_pc = PC_STORE; n_ss = in_slot;
          end
        end
      end
      if (n_pc == PC_DISCARD) begin
        r.status = n_drop;
        if (it.last && n_end) begin
          n_end = 1'b0; n_final = 1'b1; n_dp = '0;
          if (slot_valid[exp_slot]) n_drain = 1'b1;
          else begin
            n_drain = 1'b0; n_done = 1'b1;
          end
        end
      end else begin
        fits = (n_pos < it.size) && (n_pos < SIZE_W'(MAX_PAYLOAD));
        bad = !fits || (it.last && ({1'b0, n_pos} + 1'b1 != {1'b0, it.size}));
        if (n_pc == PC_STREAM) begin
          if (fits) begin
            r.out_valid = 1'b1; r.out_byte = it.data;
          end
          if (it.last) begin
            r.packet_end = 1'b1; r.ack_valid = 1'b1; r.ack_seq = expected_seq;
            n_exp = expected_seq + 1'b1; n_dp = '0;
            nslot = slot_step(exp_slot, n_exp);
            n_es = nslot;
            if (slot_valid[nslot]) n_drain = 1'b1;
            else begin
              n_drain = 1'b0;
              if (m_final) n_done = 1'b1;
            end
          end
          r.status = ST_OK;
        end else begin
          if (fits) begin
            wr_en = 1'b1; wr_addr = addr_of(n_ss, n_pos[PTR_W-1:0]);
          end
          if (it.last) begin
            cnt = fits ? {1'b0, n_pos} + 1'b1 : {1'b0, it.size};
            if (cnt > (SIZE_W+1)'(MAX_PAYLOAD)) cnt = (SIZE_W+1)'(MAX_PAYLOAD);
            len_we = 1'b1; len_wd = cnt[LEN_W-1:0];
            n_sv[n_ss] = (cnt != '0);
          end
          r.status = ST_BUFFERED;
        end
        if (bad) r.status = ST_MISMATCH;
      end
      if (it.last) begin
        n_pc = PC_IDLE; n_pos = '0;
      end else if (n_pos != '1) n_pos = n_pos + 1'b1;
    end
    r.drain_pending = n_drain;
    r.finished = n_done;
    if (!cmd.execute) wr_en = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      res <= r;
      if (len_we) slot_length[n_ss] <= len_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_seq <= '0; exp_slot <= '0; slot_valid <= '0; byte_position <= '0;
      packet_class <= PC_IDLE; drain_pointer <= '0; m_drain <= 1'b0;
      m_final <= 1'b0; m_done <= 1'b0; m_end <= 1'b0; drop_code <= ST_OK;
      store_slot <= '0;
    end else if (cmd.execute) begin
      expected_seq <= n_exp; exp_slot <= n_es; slot_valid <= n_sv;
      byte_position <= n_pos;
      packet_class <= n_pc; drain_pointer <= n_dp; m_drain <= n_drain;
      m_final <= n_final; m_done <= n_done; m_end <= n_end; drop_code <= n_drop;
      store_slot <= n_ss;
    end
  end

endmodule

FILE: test/selective_repeat_reorder_receiver_test.sv
`timescale 1ns / 100ps

module selective_repeat_reorder_receiver_test;
  import srr_pkg::*;

  localparam int unsigned WIN = 8;
  localparam int unsigned MAXP = 1024;
  localparam int unsigned ITEM_TARGET = 1800;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [55:0] s_axis_tdata = '0;  // seq_num, payload_size, data_byte
  logic s_axis_tuser = 1'b0;       // opcode
  logic s_axis_tlast = 1'b0;       // beat_last
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;       // ack_valid, ack_seq, out_valid, out_byte,
                                   // drain_pending, finished, status
  logic m_axis_tlast;              // packet_end

  selective_repeat_reorder_receiver #(.WINDOW(WIN), .MAX_PAYLOAD(MAXP)) uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  always #5 clk = ~clk;

  // receiver state mirror
  logic [31:0] end_seq = 32'hFFFF_FFFF;
  logic [31:0] exp_seq = '0;
  bit slot_full [WIN];
  int unsigned slot_len [WIN];
  logic [7:0] slot_mem [WIN*MAXP];
  int unsigned byte_pos = 0;
  pclass_t pclass = PC_IDLE;
  int unsigned drain_ptr = 0;
  bit f_drain = 0, f_final = 0, f_done = 0, f_end = 0;
  status_t drop_status = ST_OK;
  int unsigned store_idx = 0;

  item_t send_q[$];
  result_t result_q[$];
  int unsigned pushed = 0, accepted = 0, received = 0, errors = 0;
  int unsigned acks_seen = 0, bytes_seen = 0;
  int unsigned cycles = 0;
  int unsigned tx_gap = 0, rx_gap = 0;
  bit tx_burst = 0, rx_burst = 0;

  function automatic int unsigned pick_gap(input bit burst);
    int unsigned k;
    k = $urandom_range(0, 99);
    if (burst || k < 65) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void start_drain();
    drain_ptr = 0;
    if (slot_full[exp_seq % WIN]) f_drain = 1;
    else begin
      f_drain = 0;
      if (f_final) f_done = 1;
    end
  endfunction

  function automatic void predict_transfer(input item_t it);
    result_t r;
    int unsigned s, len, ptr, pos, cnt;
    bit fits, bad;
    r = '0;
    r.status = ST_OK;
    if (f_done) begin
      r.status = ST_DONE;
    end else if (it.tick) begin
      if (f_drain) begin
        s = exp_seq % WIN;
        len = slot_len[s];
        ptr = drain_ptr;
        if (!slot_full[s] || len == 0 || ptr >= len || len > MAXP) begin
          f_drain = 0;
          if (f_final) f_done = 1;
        end else begin
          if (ptr == 0 && !f_final) begin
            r.ack_valid = 1;
            r.ack_seq = exp_seq;
          end
          r.out_valid = 1;
          r.out_byte = slot_mem[s*MAXP + ptr];
          if (ptr + 1 >= len) begin
            r.packet_end = 1;
            slot_full[s] = 0;
            exp_seq = exp_seq + 1;
            start_drain();
          end else begin
            drain_ptr = ptr + 1;
          end
        end
      end
    end else if (pclass == PC_IDLE && it.size == 0) begin
      r.status = ST_ZERO;
    end else begin
      if (pclass == PC_IDLE) begin
        byte_pos = 0;
        pclass = PC_DISCARD;
        drop_status = ST_OK;
        if (f_drain) drop_status = ST_BUSY;
        else if (it.seq == end_seq) f_end = 1;
        else if (it.seq < exp_seq) begin
          drop_status = ST_DUP;
          r.ack_valid = 1;
          r.ack_seq = it.seq;
        end else if (it.size > MAXP) drop_status = ST_OVERSIZE;
        else if (it.seq == exp_seq) pclass = PC_STREAM;
        else if (32'(it.seq - exp_seq) >= WIN) drop_status = ST_WINDOW;
        else begin
          r.ack_valid = 1;
          r.ack_seq = it.seq;
          if (slot_full[it.seq % WIN]) drop_status = ST_BUFFERED;
          else begin
            pclass = PC_STORE;
            store_idx = it.seq % WIN;
          end
        end
      end
      pos = byte_pos;
      if (pclass == PC_DISCARD) begin
        r.status = drop_status;
        if (it.last && f_end) begin
          f_end = 0;
          f_final = 1;
          start_drain();
        end
      end else begin
        fits = pos < it.size && pos < MAXP;
        bad = !fits || (it.last && pos + 1 != it.size);
        if (pclass == PC_STREAM) begin
          if (fits) begin
            r.out_valid = 1;
            r.out_byte = it.data;
          end
          if (it.last) begin
            r.packet_end = 1;
            r.ack_valid = 1;
            r.ack_seq = exp_seq;
            exp_seq = exp_seq + 1;
            start_drain();
          end
          r.status = ST_OK;
        end else begin
          if (fits) slot_mem[store_idx*MAXP + pos] = it.data;
          if (it.last) begin
            cnt = fits ? pos + 1 : it.size;
            if (cnt > MAXP) cnt = MAXP;
            slot_len[store_idx] = cnt;
            slot_full[store_idx] = cnt != 0;
          end
          r.status = ST_BUFFERED;
        end
        if (bad) r.status = ST_MISMATCH;
      end
      if (it.last) begin
        pclass = PC_IDLE;
        byte_pos = 0;
      end else if (pos < 16'hFFFF) begin
        byte_pos = pos + 1;
      end
    end
    r.drain_pending = f_drain;
    r.finished = f_done;
    result_q.push_back(r);
  endfunction

  // driver
  always @(posedge clk) begin
    item_t it;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        it.seq = s_axis_tdata[31:0];
        it.size = s_axis_tdata[47:32];
        it.data = s_axis_tdata[55:48];
        it.tick = s_axis_tuser;
        it.last = s_axis_tlast;
        predict_transfer(it);
        accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (send_q.size() > 0) begin
          it = send_q.pop_front();
          s_axis_tdata <= {it.data, it.size, it.seq};
          s_axis_tuser <= it.tick;
          s_axis_tlast <= it.last;
          s_axis_tvalid <= 1'b1;
          tx_gap = pick_gap(tx_burst);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      if ($urandom_range(0, 299) == 0) tx_burst = !tx_burst;
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("transfer %0d: %s expected %0h got %0h", received, name, want, got);
    end
  endfunction

  // monitor
  always @(posedge clk) begin
    result_t r;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end else if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transfer %h", m_axis_tdata);
        end else begin
          r = result_q.pop_front();
          check_field("ack_valid", 32'(r.ack_valid), 32'(m_axis_tdata[0]));
          check_field("ack_seq", r.ack_seq, m_axis_tdata[32:1]);
          check_field("out_valid", 32'(r.out_valid), 32'(m_axis_tdata[33]));
          check_field("out_byte", 32'(r.out_byte), 32'(m_axis_tdata[41:34]));
          check_field("packet_end", 32'(r.packet_end), 32'(m_axis_tlast));
          check_field("drain_pending", 32'(r.drain_pending), 32'(m_axis_tdata[42]));
          check_field("finished", 32'(r.finished), 32'(m_axis_tdata[43]));
          check_field("status", 32'(r.status), 32'(m_axis_tdata[47:44]));
          if (r.ack_valid) acks_seen++;
          if (r.out_valid) bytes_seen++;
        end
        received++;
      end
      if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        rx_gap = pick_gap(rx_burst);
      end
      if ($urandom_range(0, 299) == 0) rx_burst = !rx_burst;
    end
  end

  task automatic push_item(input bit tick, input logic [31:0] seq, input logic [15:0] size,
                           input logic [7:0] data, input bit last);
    item_t it;
    it.seq = seq;
    it.size = size;
    it.data = data;
    it.tick = tick;
    it.last = last;
    send_q.push_back(it);
    pushed++;
  endtask

  // beats may differ from size to provoke length mismatch
  task automatic push_packet(input logic [31:0] seq, input logic [15:0] size,
                             input int unsigned beats);
    for (int unsigned i = 0; i < beats; i++)
      push_item(1'b0, seq, size, 8'($urandom), i + 1 == beats);
  endtask

  task automatic wait_sent();
    while (accepted != pushed) @(negedge clk);
  endtask

  task automatic wait_idle();
    while (accepted != pushed || result_q.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_end_seq(input logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    end_seq = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_traffic();
    int unsigned k, size, beats;
    logic [31:0] seq;
    while (pushed < ITEM_TARGET) begin
      k = $urandom_range(0, 99);
      if (f_drain && k < 80) begin
        push_item(1'b1, $urandom, 16'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        k = $urandom_range(0, 99);
        size = ($urandom_range(0, 199) == 0) ? $urandom_range(100, MAXP)
                                             : $urandom_range(1, 6);
        if (k < 50) seq = exp_seq;
        else if (k < 78) seq = exp_seq + $urandom_range(1, WIN - 1);
        else if (k < 85) seq = exp_seq - $urandom_range(1, 5);
        else if (k < 90) seq = exp_seq + $urandom_range(WIN, WIN + 20);
        else if (k < 93) begin
          seq = exp_seq;
          size = $urandom_range(MAXP + 1, 65535);
        end else if (k < 97) begin
          seq = $urandom;
          size = $urandom_range(0, 65535);
        end else begin
          seq = exp_seq;
          size = 0;
        end
        if (seq == end_seq) seq = seq ^ 32'h1;
        k = $urandom_range(0, 99);
        if (size > MAXP || size == 0) beats = $urandom_range(1, 3);
        else if (k < 90) beats = size;
        else if (k < 95) beats = size + 1;
        else beats = (size > 1) ? size - 1 : 2;
        push_packet(seq, 16'(size), beats);
      end
      wait_sent();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_end_seq(32'hFFFF_FFFF);
    push_item(1, 0, 0, 0, 0);
    push_item(0, 0, 0, 8'h55, 1);
    push_item(0, 0, 2, 8'h00, 0);
    push_item(0, 0, 2, 8'hFF, 1);
    push_packet(2, 1, 1);
    push_packet(2, 1, 1);
    push_packet(0, 1, 1);
    push_packet(1, 1025, 1);
    push_packet(1, 16'hFFFF, 2);
    push_packet(9, 1, 1);
    push_packet(1, 2, 3);
    push_packet(3, 1, 1);
    push_item(1, 0, 0, 0, 0);
    push_item(1, 0, 0, 0, 0);
    push_packet(3, 3, 2);
    push_packet(5, 2, 3);
    push_packet(4, 2, 1);
    push_item(1, 0, 0, 0, 0);
    push_item(1, 0, 0, 0, 0);
    wait_idle();

    write_end_seq($urandom | 32'h8000_0000);
    random_traffic();
    while (f_drain) begin
      push_item(1, 0, 0, 0, 0);
      wait_sent();
    end
    wait_idle();

    write_end_seq(32'h0000_0000);
    push_packet(exp_seq + 1, 2, 2);
    push_packet(0, 4, 4);
    push_packet(exp_seq, 1, 1);
    push_item(1, 0, 0, 0, 0);
    wait_idle();

    $display("%0d transfers in, %0d out, %0d acks, %0d bytes delivered",
             accepted, received, acks_seen, bytes_seen);
    $display("covered stream, store, drain, discard cases and final end sequence");
    if (errors == 0 && result_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
